// File: hw/rtl/perspective_screen_projection_assert.svh
// Assertion macros for the perspective screen projection block
`ifndef PERSPECTIVE_SCREEN_PROJECTION_ASSERT_SVH
`define PERSPECTIVE_SCREEN_PROJECTION_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define PSP_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("psp assertion failed");

// Next-cycle implication, checked outside reset
`define PSP_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("psp assertion failed");

`endif

// File: hw/rtl/psp_pkg.sv
// Package: widths, register indexes and arithmetic helpers of the projection block
`default_nettype none
package psp_pkg;

  localparam int CW      = 49;  // signed clip value width
  localparam int MAG_W   = 48;  // clip magnitude / divisor width
  localparam int QW      = 33;  // quotient bits (17 integer, 16 fraction)
  localparam int DIV_STEPS = QW;
  localparam int FRAC    = 16;
  localparam int NDC_W   = 35;  // signed ndc, up to +-2^33
  localparam int PW      = 50;  // ndc times viewport size
  localparam int SUM_W   = 52;
  localparam int DIM_W   = 14;
  localparam int ADDR_W  = 6;
  localparam int DATA_W  = 64;
  localparam int NUM_MAT = 6;
  localparam int W_MIN   = 66;
  localparam int HALF_Q16 = 32768;

  localparam logic [2:0] REG_ROW_X_FIRST  = 3'd0;
  localparam logic [2:0] REG_ROW_X_SECOND = 3'd1;
  localparam logic [2:0] REG_ROW_Y_FIRST  = 3'd2;
  localparam logic [2:0] REG_ROW_Y_SECOND = 3'd3;
  localparam logic [2:0] REG_ROW_W_FIRST  = 3'd4;
  localparam logic [2:0] REG_ROW_W_SECOND = 3'd5;
  localparam logic [2:0] REG_WIDTH        = 3'd6;
  localparam logic [2:0] REG_HEIGHT       = 3'd7;

  // Flags that travel alongside the divider stages
  typedef struct packed {
    logic v;
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
    logic front;
  } side_t;

  // Signed ndc from quotient, clamp and sign, times viewport size
  function automatic logic signed [PW-1:0] ndc_scale(input logic [QW-1:0] q,
                                                     input logic ovf, input logic neg,
                                                     input logic [DIM_W-1:0] dim);
    logic [NDC_W-1:0] mag;
    logic [NDC_W-1:0] ndc;
    mag = ovf ? (NDC_W'(1) << QW) : NDC_W'(q);
    ndc = neg ? NDC_W'(-mag) : mag;
    ndc_scale = $signed(ndc) * $signed({1'b0, dim});
  endfunction

  // Divide by two, truncating toward zero
  function automatic logic signed [SUM_W-1:0] half_trunc(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] adj;
    adj = p + PW'(p[PW-1]);
    half_trunc = SUM_W'(adj >>> 1);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    if (v > SUM_W'(64'sd2147483647)) sat32 = 32'sh7fffffff;
    else if (v < -SUM_W'(64'sd2147483648)) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/psp_point_if.sv
// Stream interfaces: world points in, screen pixels out
`default_nettype none
interface psp_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface psp_pixel_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pixel_x;
  logic signed [31:0] pixel_y;
  logic               in_front;
  modport source (output valid, pixel_x, pixel_y, in_front, input ready);
  modport sink   (input valid, pixel_x, pixel_y, in_front, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/psp_div.sv
// Pipelined radix-2 restoring divider: q = floor(n * 2^16 / d), one bit per stage
`default_nettype none
module psp_div import psp_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [MAG_W-1:0] n_i,
  input  wire logic [MAG_W-1:0] d_i,
  output logic      [QW-1:0]    q_o
);

  logic [MAG_W-1:0] rem_q [DIV_STEPS];
  logic [MAG_W-1:0] n_q   [DIV_STEPS];
  logic [MAG_W-1:0] d_q   [DIV_STEPS];
  logic [QW-1:0]    q_q   [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    localparam int Bit = DIV_STEPS - 1 - k;
    logic [MAG_W-1:0] r_src, n_src, d_src;
    logic [QW-1:0]    q_src;
    logic             nb;
    logic [MAG_W:0]   t;
    logic             ge;

    // Stage 0 starts from the integer bits above the quotient range
    if (k == 0) begin : g_first
      assign r_src = n_i >> (FRAC + 1);
      assign n_src = n_i;
      assign d_src = d_i;
      assign q_src = '0;
    end else begin : g_next
      assign r_src = rem_q[k-1];
      assign n_src = n_q[k-1];
      assign d_src = d_q[k-1];
      assign q_src = q_q[k-1];
    end

    // Dividend bit, zero in the fraction part
    if (Bit >= FRAC) begin : g_nbit
      assign nb = n_src[Bit-FRAC];
    end else begin : g_zbit
      assign nb = 1'b0;
    end

    always_comb begin
      t  = {r_src, nb};
      ge = (t >= {1'b0, d_src});
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? MAG_W'(t - {1'b0, d_src}) : MAG_W'(t);
        n_q[k]   <= n_src;
        d_q[k]   <= d_src;
        q_q[k]   <= {q_src[QW-2:0], ge};
      end
    end
  end

  assign q_o = q_q[DIV_STEPS-1];

endmodule
`default_nettype wire

// File: hw/rtl/perspective_screen_projection.sv
// Top level: perspective projection of world points to viewport pixels
// Takes one point and gives one result per cycle if the output keeps up:
// multiply, sum, magnitude and range check, a 33-stage one-bit-per-stage
// divider for x/w and y/w, viewport scale, and offset with saturation. A
// one-entry skid register on the output lets the pipeline take one more point
// after the output stalls. Points with w below 0.001 give in_front 0 and zero
// pixels. Matrix rows and viewport size are written through the APB port
// (64-bit registers at 8-byte spacing) by the user only while idle; unenforced.
`default_nettype none
`include "perspective_screen_projection_assert.svh"
module perspective_screen_projection import psp_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  psp_point_if.sink              point_i,
  psp_pixel_if.source            pixel_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  // ---------------- configuration registers ----------------
  logic [DATA_W-1:0] mat_q [NUM_MAT];
  logic [DIM_W-1:0]  width_q, height_q;
  logic [2:0]        reg_idx;

  assign reg_idx = paddr[ADDR_W-1:3];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_MAT; i++) mat_q[i] <= '0;
      width_q  <= DIM_W'(640);
      height_q <= DIM_W'(480);
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
        default:    mat_q[reg_idx] <= pwdata;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WIDTH:  prdata = DATA_W'(width_q);
      REG_HEIGHT: prdata = DATA_W'(height_q);
      default:    prdata = mat_q[reg_idx];
    endcase
  end

  // ---------------- pipeline control ----------------
  logic en;
  logic sk_valid_q;
  logic in_fire;

  assign en            = !sk_valid_q;
  assign point_i.ready = en;
  assign in_fire       = point_i.valid && en;

  // ---------------- stage A: nine products ----------------
  logic signed [31:0] coef [9];
  logic signed [31:0] crd  [9];
  logic signed [63:0] prod_d [9];
  logic signed [63:0] prod_q [9];
  logic               va_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      coef[3*r]   = mat_q[2*r][63:32];
      coef[3*r+1] = mat_q[2*r][31:0];
      coef[3*r+2] = mat_q[2*r+1][63:32];
      crd[3*r]    = point_i.point_x;
      crd[3*r+1]  = point_i.point_y;
      crd[3*r+2]  = point_i.point_z;
    end
    for (int j = 0; j < 9; j++) prod_d[j] = coef[j] * crd[j];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 9; j++) prod_q[j] <= prod_d[j];
    end
  end

  // ---------------- stage B: floor to Q16.16 and sum ----------------
  logic signed [CW-1:0] clip_d [3];
  logic signed [CW-1:0] clip_q [3];
  logic signed [31:0]   offs;
  logic                 vb_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      offs = mat_q[2*r+1][31:0];
      clip_d[r] = CW'(prod_q[3*r] >>> FRAC) + CW'(prod_q[3*r+1] >>> FRAC)
                + CW'(prod_q[3*r+2] >>> FRAC) + CW'(offs);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) clip_q[r] <= clip_d[r];
    end
  end

  // ---------------- stage C: magnitudes, w check, clamp check ----------------
  logic [MAG_W-1:0] nx_d, ny_d, nx_q, ny_q, d_q;
  side_t            sc_d, sc_q;
  logic [CW-1:0]    negx_c, negy_c;

  always_comb begin
    negx_c   = CW'(-clip_q[0]);
    negy_c   = CW'(-clip_q[1]);
    nx_d     = clip_q[0][CW-1] ? negx_c[MAG_W-1:0] : clip_q[0][MAG_W-1:0];
    ny_d     = clip_q[1][CW-1] ? negy_c[MAG_W-1:0] : clip_q[1][MAG_W-1:0];
    sc_d.v     = vb_q;
    sc_d.neg_x = clip_q[0][CW-1];
    sc_d.neg_y = clip_q[1][CW-1];
    sc_d.front = clip_q[2] >= CW'(W_MIN);
    // integer part of n/d reaches 2^17
    sc_d.ovf_x = {17'b0, nx_d} >= {clip_q[2][MAG_W-1:0], 17'b0};
    sc_d.ovf_y = {17'b0, ny_d} >= {clip_q[2][MAG_W-1:0], 17'b0};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q <= nx_d;
      ny_q <= ny_d;
      d_q  <= clip_q[2][MAG_W-1:0];
    end
  end

  // ---------------- dividers ----------------
  logic [QW-1:0] qx, qy;
  side_t         side_q [DIV_STEPS];

  psp_div u_div_x (.clk_i, .en_i(en), .n_i(nx_q), .d_i(d_q), .q_o(qx));
  psp_div u_div_y (.clk_i, .en_i(en), .n_i(ny_q), .d_i(d_q), .q_o(qy));

  // ---------------- stage E: ndc times viewport size ----------------
  logic signed [PW-1:0] px_q, py_q;
  logic                 ve_q, fe_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q <= ndc_scale(qx, side_q[DIV_STEPS-1].ovf_x, side_q[DIV_STEPS-1].neg_x, width_q);
      py_q <= ndc_scale(qy, side_q[DIV_STEPS-1].ovf_y, side_q[DIV_STEPS-1].neg_y, height_q);
      fe_q <= side_q[DIV_STEPS-1].front;
    end
  end

  // ---------------- stage F: center and half-pixel offset, saturation ----------------
  logic signed [SUM_W-1:0] cx_c, cy_c, sx_c, sy_c;
  logic signed [31:0]      pix_x_d, pix_y_d, pix_x_q, pix_y_q;
  logic signed [31:0]      sk_x_q, sk_y_q;
  logic                    vf_q, ff_q, sk_f_q;

  always_comb begin
    cx_c    = $signed(SUM_W'({width_q >> 1, 16'b0}));
    cy_c    = $signed(SUM_W'({height_q >> 1, 16'b0}));
    sx_c    = cx_c + half_trunc(px_q) + SUM_W'(HALF_Q16);
    sy_c    = cy_c - (half_trunc(py_q) + SUM_W'(HALF_Q16));
    pix_x_d = fe_q ? sat32(sx_c) : '0;
    pix_y_d = fe_q ? sat32(sy_c) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pix_x_q <= pix_x_d;
      pix_y_q <= pix_y_d;
      ff_q    <= fe_q;
    end
  end

  // ---------------- valid bits ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      sc_q <= '0;
      for (int k = 0; k < DIV_STEPS; k++) side_q[k] <= '0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
    end else if (en) begin
      va_q      <= in_fire;
      vb_q      <= va_q;
      sc_q      <= sc_d;
      side_q[0] <= sc_q;
      for (int k = 1; k < DIV_STEPS; k++) side_q[k] <= side_q[k-1];
      ve_q      <= side_q[DIV_STEPS-1].v;
      vf_q      <= ve_q;
    end
  end

  // ---------------- output skid register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sk_valid_q <= 1'b0;
    end else if (en && vf_q && !pixel_o.ready) begin
      sk_valid_q <= 1'b1;
    end else if (sk_valid_q && pixel_o.ready) begin
      sk_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && vf_q && !pixel_o.ready) begin
      sk_x_q <= pix_x_q;
      sk_y_q <= pix_y_q;
      sk_f_q <= ff_q;
    end
  end

  assign pixel_o.valid    = sk_valid_q || vf_q;
  assign pixel_o.pixel_x  = sk_valid_q ? sk_x_q : pix_x_q;
  assign pixel_o.pixel_y  = sk_valid_q ? sk_y_q : pix_y_q;
  assign pixel_o.in_front = sk_valid_q ? sk_f_q : ff_q;

  // ---------------- assertions ----------------
  `PSP_ASSERT_IMP(a_behind_zero, clk_i, rst_ni,
                  pixel_o.valid && !pixel_o.in_front,
                  pixel_o.pixel_x == 0 && pixel_o.pixel_y == 0)
  `PSP_ASSERT_NXT(a_skid_hold, clk_i, rst_ni,
                  sk_valid_q && !pixel_o.ready,
                  sk_valid_q && $stable(sk_x_q) && $stable(sk_y_q))
  `PSP_ASSERT_NXT(a_accept_enters, clk_i, rst_ni, in_fire, va_q)
  `PSP_ASSERT_NXT(a_stall_freezes, clk_i, rst_ni,
                  sk_valid_q && !pixel_o.ready, $stable(vf_q) && $stable(pix_x_q))

endmodule
`default_nettype wire

// File: test/perspective_screen_projection_tb.sv
// Testbench for the perspective screen projection block: directed table, then random points
`default_nettype none
module perspective_screen_projection_tb import psp_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 38;
  localparam longint CYCLE_LIMIT = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  psp_point_if point_if ();
  psp_pixel_if pixel_if ();

  perspective_screen_projection uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .point_i(point_if.sink), .pixel_o(pixel_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk_i = ~clk_i;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               front;
  } pixel_t;

  // Shadow of the configuration
  logic [63:0] mat_q [NUM_MAT];
  logic [13:0] width_q, height_q;

  pixel_t pending_pixels [$];
  int     errors = 0;
  longint cycles = 0;

  // Q32.32 product shifted to Q16.16, toward minus infinity
  function automatic longint prod_q16(logic [31:0] c, logic signed [31:0] v);
    longint p;
    p = longint'($signed(c)) * longint'(v);
    return p >>> 16;
  endfunction

  function automatic longint clip_row(int r, logic signed [31:0] x, logic signed [31:0] y,
                                      logic signed [31:0] z);
    return prod_q16(mat_q[r][63:32], x) + prod_q16(mat_q[r][31:0], y) +
           prod_q16(mat_q[r+1][63:32], z) + longint'($signed(mat_q[r+1][31:0]));
  endfunction

  // c / w in Q16.16, truncated toward zero, integer part clamped
  function automatic longint ndc_of(longint c, longint w);
    logic [63:0] n, q, r;
    n = (c < 0) ? -c : c;
    q = n / w;
    r = n % w;
    if (q >= 131072) begin
      q = 131072;
      r = 0;
    end
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= w) begin
        r = r - w;
        q = q | 1;
      end
    end
    return (c < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic pixel_t project_point(logic signed [31:0] x, logic signed [31:0] y,
                                           logic signed [31:0] z);
    pixel_t res;
    longint cx, cy, cw, wd, ht, a, b;
    cx = clip_row(0, x, y, z);
    cy = clip_row(2, x, y, z);
    cw = clip_row(4, x, y, z);
    wd = width_q;
    ht = height_q;
    if (cw < W_MIN) begin
      res = '0;
      return res;
    end
    a = (wd / 2) * 65536 + (ndc_of(cx, cw) * wd) / 2 + HALF_Q16;
    b = (ht / 2) * 65536 - ((ndc_of(cy, cw) * ht) / 2 + HALF_Q16);
    res.px = clamp32(a);
    res.py = clamp32(b);
    res.front = 1'b1;
    return res;
  endfunction

  // APB write: setup then access
  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 3'b000}); pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx < NUM_MAT) mat_q[idx] = val;
    else if (idx == REG_WIDTH) width_q = val[13:0];
    else height_q = val[13:0];
  endtask

  task automatic wait_drained();
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // Send one point; a typed expectation overrides the prediction
  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z, bit use_fixed, pixel_t fixed_res);
    int gap;
    gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16));
    if (gap != 0) begin
      point_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    point_if.valid <= 1'b1;
    point_if.point_x <= x;
    point_if.point_y <= y;
    point_if.point_z <= z;
    @(posedge clk_i);
    while (!point_if.ready) @(posedge clk_i);
    pending_pixels.push_back(use_fixed ? fixed_res : project_point(x, y, z));
  endtask

  task automatic end_burst();
    point_if.valid <= 1'b0;
  endtask

  // Identity-like matrix with w = z, so ndc = x/z, y/z
  task automatic load_camera(logic [31:0] sx, logic [31:0] sy, logic [31:0] wz,
                             logic [31:0] wc, logic [13:0] wd, logic [13:0] ht);
    write_reg(REG_ROW_X_FIRST, {sx, 32'h0});
    write_reg(REG_ROW_X_SECOND, 64'h0);
    write_reg(REG_ROW_Y_FIRST, {32'h0, sy});
    write_reg(REG_ROW_Y_SECOND, 64'h0);
    write_reg(REG_ROW_W_FIRST, 64'h0);
    write_reg(REG_ROW_W_SECOND, {wz, wc});
    write_reg(REG_WIDTH, {50'h0, wd});
    write_reg(REG_HEIGHT, {50'h0, ht});
  endtask

  typedef struct {
    logic signed [31:0] x, y, z;
    bit                 fixed;
    pixel_t             res;
  } point_row_t;

  point_row_t dir_rows [] = '{
    // all-zero matrix after reset: w = 0, behind
    '{32'sh0, 32'sh0, 32'sh0, 1'b1, '0},
    '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b1, '0},
    '{32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b1, '0}
  };

  point_row_t cam_rows [] = '{
    // point on axis at z = 1: screen center + 0.5
    '{32'sh0, 32'sh0, 32'sh10000, 1'b0, '0},
    '{32'sh10000, 32'sh10000, 32'sh10000, 1'b0, '0},
    '{-32'sh10000, -32'sh10000, 32'sh10000, 1'b0, '0},
    // w just at and below the threshold
    '{32'sh1, 32'sh1, 32'sd66, 1'b0, '0},
    '{32'sh1, 32'sh1, 32'sd65, 1'b1, '0},
    '{32'sh0, 32'sh0, -32'sh10000, 1'b1, '0},
    // huge x over tiny w: clamp and saturation
    '{32'sh7fffffff, 32'sh80000000, 32'sd66, 1'b0, '0},
    '{32'sh80000000, 32'sh7fffffff, 32'sd66, 1'b0, '0},
    '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0, '0},
    '{32'sh80000000, 32'sh80000000, 32'sh7fffffff, 1'b0, '0},
    '{32'sh12345, -32'sh6789a, 32'sh30000, 1'b0, '0}
  };

  // Result checker with random stall
  initial begin
    pixel_t exp_res;
    int stall;
    pixel_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (stall != 0) begin
        pixel_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pixel_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!pixel_if.valid) @(posedge clk_i);
      if (pending_pixels.size() == 0) begin
        $display("%0t unexpected result: px %h py %h front %b", $realtime,
                 pixel_if.pixel_x, pixel_if.pixel_y, pixel_if.in_front);
        errors++;
      end else begin
        exp_res = pending_pixels.pop_front();
        if (pixel_if.pixel_x !== exp_res.px) begin
          $display("%0t pixel_x expected %h actual %h", $realtime, exp_res.px,
                   pixel_if.pixel_x);
          errors++;
        end
        if (pixel_if.pixel_y !== exp_res.py) begin
          $display("%0t pixel_y expected %h actual %h", $realtime, exp_res.py,
                   pixel_if.pixel_y);
          errors++;
        end
        if (pixel_if.in_front !== exp_res.front) begin
          $display("%0t in_front expected %b actual %b", $realtime, exp_res.front,
                   pixel_if.in_front);
          errors++;
        end
      end
    end
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Stimulus
  initial begin
    logic signed [31:0] rx, ry, rz;
    point_if.valid = 1'b0;
    point_if.point_x = '0;
    point_if.point_y = '0;
    point_if.point_z = '0;
    for (int i = 0; i < NUM_MAT; i++) mat_q[i] = '0;
    width_q = 14'd640;
    height_q = 14'd480;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (LATENCY + 4) @(posedge clk_i);

    foreach (dir_rows[i]) send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
                                     dir_rows[i].fixed, dir_rows[i].res);
    end_burst();
    wait_drained();

    load_camera(32'h10000, 32'h10000, 32'h10000, 32'h0, 14'd640, 14'd480);
    foreach (cam_rows[i]) send_point(cam_rows[i].x, cam_rows[i].y, cam_rows[i].z,
                                     cam_rows[i].fixed, cam_rows[i].res);
    end_burst();
    wait_drained();

    // Random phases over several settings, extremes of viewport size included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_camera(32'h10000, 32'h10000, 32'h10000, 32'h0, 14'd1, 14'd1);
        1: load_camera(32'h20000, 32'hfffe0000, 32'h10000, 32'h8000, 14'd8192, 14'd8192);
        2: load_camera(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                       14'd3, 14'd8191);
        default: begin
          for (int k = 0; k < NUM_MAT; k++)
            write_reg(3'(k), {$urandom(), $urandom()} >> $urandom_range(0, 20));
          write_reg(REG_WIDTH, 64'($urandom_range(1, 8192)));
          write_reg(REG_HEIGHT, 64'($urandom_range(1, 8192)));
        end
      endcase
      for (int n = 0; n < 65; n++) begin
        case ($urandom_range(0, 2))
          0: begin
            rx = $urandom(); ry = $urandom(); rz = $urandom();
          end
          1: begin
            rx = $signed(32'($urandom_range(0, 32'h100000))) - 32'sh80000;
            ry = $signed(32'($urandom_range(0, 32'h100000))) - 32'sh80000;
            rz = 32'($urandom_range(0, 32'h200000));
          end
          default: begin
            rx = $urandom() >>> $urandom_range(0, 31);
            ry = -($urandom() >> $urandom_range(0, 31));
            rz = $urandom() >> $urandom_range(0, 31);
          end
        endcase
        send_point(rx, ry, rz, 1'b0, '0);
      end
      end_burst();
      // sender holds off until every result is back
      wait_drained();
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
